/* rtl/arruda_boyce_deviatoric_stress_defines.svh */
// Assertion macros shared by the checker of the deviatoric stress block.
// Needs nothing else; the checker takes it by include.
`ifndef ARRUDA_BOYCE_DEVIATORIC_STRESS_DEFINES_SVH
`define ARRUDA_BOYCE_DEVIATORIC_STRESS_DEFINES_SVH

// Property checked at each clock edge outside reset.
`define ABD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at each clock edge, reset included.
`define ABD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/abd_pkg.sv */
// Shared widths, constants and types of the deviatoric stress pipeline.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package abd_pkg;
    localparam int IN_W    = 32;
    localparam int I1_W    = 34;
    localparam int D_W     = 35;
    localparam int FQ_W    = 58;
    localparam int F_W     = 59;
    localparam int ACC_W   = 64;
    localparam int SQ_W    = 64;
    localparam int DEN_W   = 33;
    localparam int NDEN_W  = 32;
    localparam int OUT_W   = 32;
    localparam int MUL_LAT = 4;
    localparam int LANES   = 6;
    localparam int ADDR_W  = 3;

    localparam logic REG_MU = 1'b0;
    localparam logic REG_N  = 1'b1;

    localparam logic [31:0] MU_RESET = 32'd65536;
    localparam logic [31:0] N_RESET  = 32'd524288;

    localparam logic [63:0] SAT64   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] T_LIMIT = 64'd3 << 45;

    localparam logic [63:0] SERIES [5] = '{
        64'd2147483648, 64'd858993459, 64'd404954059, 64'd186524294, 64'd82711986
    };

    typedef struct packed {
        logic                        bad;
        logic [IN_W-1:0]             j;
        logic [LANES-1:0][D_W-1:0]   d;
    } t_side;

    typedef struct packed {
        logic [F_W-1:0] f;
        t_side          side;
    } t_horn;
endpackage

`default_nettype wire

/* rtl/abd_udiv.sv */
// Restoring unsigned divider, one quotient bit per pipeline stage.
// Carries a side payload and a valid bit with each beat; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module abd_udiv #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 33,
    parameter int PAY_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_q,
    output logic [PAY_W-1:0] o_pay
);
    localparam int STEP_W = NUM_W + DEN_W;

    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [PAY_W-1:0] r_pay [NUM_W];
    logic [NUM_W-1:0] r_vld;
    logic [NUM_W-1:0] n_num [NUM_W];
    logic [DEN_W-1:0] n_rem [NUM_W];

    function automatic logic [STEP_W-1:0] div_step(input logic [NUM_W-1:0] num,
                                                   input logic [DEN_W-1:0] rem,
                                                   input logic [DEN_W-1:0] den);
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           fit;
        trial = {rem, num[NUM_W-1]};
        diff  = trial - {1'b0, den};
        fit   = (trial >= {1'b0, den});
        div_step = {(fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0]), num[NUM_W-2:0], fit};
    endfunction

    always_comb begin
        {n_rem[0], n_num[0]} = div_step(i_num, {DEN_W{1'b0}}, i_den);
        for (int s = 1; s < NUM_W; s++) begin
            {n_rem[s], n_num[s]} = div_step(r_num[s-1], r_rem[s-1], r_den[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num    <= n_num;
            r_rem    <= n_rem;
            r_den[0] <= i_den;
            r_pay[0] <= i_pay;
            for (int s = 1; s < NUM_W; s++) begin
                r_den[s] <= r_den[s-1];
                r_pay[s] <= r_pay[s-1];
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_q     = r_num[NUM_W-1];
    assign o_pay   = r_pay[NUM_W-1];
endmodule

`default_nettype wire

/* rtl/abd_mul.sv */
// Signed multiply with rounded right shift and magnitude saturation, four stages.
// The 64 by 64 product is built from four 32 by 32 partial products; uses abd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abd_mul #(
    parameter int          AW    = 64,
    parameter int          BW    = 64,
    parameter int          SH    = 32,
    parameter logic [63:0] LIM   = abd_pkg::SAT64,
    parameter int          PAY_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    input  logic [PAY_W-1:0]     i_pay,
    output logic                 o_valid,
    output logic signed [63:0]   o_p,
    output logic [PAY_W-1:0]     o_pay
);
    import abd_pkg::*;

    localparam logic [127:0] RND = 128'd1 << (SH - 1);

    logic [AW-1:0]      w_ua;
    logic [AW-1:0]      w_ma;
    logic [BW-1:0]      w_ub;
    logic [BW-1:0]      w_mb;
    logic [127:0]       w_sum;
    logic [127:0]       w_q;
    logic [63:0]        w_mag;

    logic [MUL_LAT-1:0] r_vld;
    logic [PAY_W-1:0]   r_pay [MUL_LAT];
    logic               r0_neg;
    logic [63:0]        r0_ma;
    logic [63:0]        r0_mb;
    logic               r1_neg;
    logic [63:0]        r1_p00;
    logic [63:0]        r1_p01;
    logic [63:0]        r1_p10;
    logic [63:0]        r1_p11;
    logic               r2_neg;
    logic [127:0]       r2_sum;
    logic signed [63:0] r3_p;

    assign w_ua = i_a;
    assign w_ub = i_b;
    assign w_ma = i_a[AW-1] ? (~w_ua + 1'b1) : w_ua;
    assign w_mb = i_b[BW-1] ? (~w_ub + 1'b1) : w_ub;

    assign w_sum = {64'd0, r1_p00} + {32'd0, r1_p01, 32'd0} + {32'd0, r1_p10, 32'd0}
                 + {r1_p11, 64'd0} + RND;
    assign w_q   = r2_sum >> SH;
    assign w_mag = (w_q > {64'd0, LIM}) ? LIM : w_q[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[MUL_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay[0] <= i_pay;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_pay[k] <= r_pay[k-1];
            end
            r0_neg <= i_a[AW-1] ^ i_b[BW-1];
            r0_ma  <= 64'(w_ma);
            r0_mb  <= 64'(w_mb);
            r1_neg <= r0_neg;
            r1_p00 <= r0_ma[31:0]  * r0_mb[31:0];
            r1_p01 <= r0_ma[31:0]  * r0_mb[63:32];
            r1_p10 <= r0_ma[63:32] * r0_mb[31:0];
            r1_p11 <= r0_ma[63:32] * r0_mb[63:32];
            r2_neg <= r1_neg;
            r2_sum <= w_sum;
            r3_p   <= signed'(r2_neg ? (~w_mag + 1'b1) : w_mag);
        end
    end

    assign o_valid = r_vld[MUL_LAT-1];
    assign o_p     = r3_p;
    assign o_pay   = r_pay[MUL_LAT-1];
endmodule

`default_nettype wire

/* rtl/abd_horner.sv */
// One Horner step of the series: acc*f rounded, then the next coefficient added.
// Uses abd_mul and the types of abd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abd_horner #(
    parameter logic [63:0] COEF = abd_pkg::SERIES[0]
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [63:0] i_acc,
    input  abd_pkg::t_horn     i_pay,
    output logic               o_valid,
    output logic signed [63:0] o_acc,
    output abd_pkg::t_horn     o_pay
);
    import abd_pkg::*;

    localparam int HP_W = $bits(t_horn);

    logic signed [63:0] w_prod;
    logic [HP_W-1:0]    w_pay;
    logic               w_vld;
    logic [64:0]        w_sum;

    logic               r_vld;
    logic signed [63:0] r_acc;
    t_horn              r_pay;

    abd_mul #(
        .AW   (ACC_W),
        .BW   (F_W),
        .SH   (32),
        .LIM  (SAT64),
        .PAY_W(HP_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_valid(i_valid),
        .i_a    (i_acc),
        .i_b    (signed'(i_pay.f)),
        .i_pay  (i_pay),
        .o_valid(w_vld),
        .o_p    (w_prod),
        .o_pay  (w_pay)
    );

    assign w_sum = {w_prod[63], w_prod} + {1'b0, COEF};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= signed'((!w_sum[64] && w_sum[63]) ? SAT64 : w_sum[63:0]);
            r_pay <= t_horn'(w_pay);
        end
    end

    assign o_valid = r_vld;
    assign o_acc   = r_acc;
    assign o_pay   = r_pay;
endmodule

`default_nettype wire

/* rtl/arruda_boyce_deviatoric_stress.sv */
// Top level of the Arruda-Boyce deviatoric stress pipeline with its register port.
// Uses abd_pkg, abd_udiv, abd_mul and abd_horner.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  input    | in        | i_valid / o_stall  | i_b_xx .. i_b_xz, i_volume_ratio
//  output   | out       | o_valid / i_stall  | o_s_xx .. o_s_xz, o_bad_volume
//  config   | in / out  | psel, penable      | paddr, pwdata, prdata, pready
//
// One beat enters per cycle while o_stall is low. The pipeline depth comes mainly
// from the two restoring dividers (58 and 64 stages) and the six four-stage
// multipliers in series. Reset clears only the valid bits and the registers.
// A stalled output parks one beat in a skid register; only then does the pipeline
// freeze and o_stall rise, and nothing in flight is lost.
`timescale 1ns / 1ps
`default_nettype none

module arruda_boyce_deviatoric_stress (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [31:0]              i_b_xx,
    input  logic signed [31:0]              i_b_yy,
    input  logic signed [31:0]              i_b_zz,
    input  logic signed [31:0]              i_b_xy,
    input  logic signed [31:0]              i_b_yz,
    input  logic signed [31:0]              i_b_xz,
    input  logic signed [31:0]              i_volume_ratio,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [31:0]              o_s_xx,
    output logic signed [31:0]              o_s_yy,
    output logic signed [31:0]              o_s_zz,
    output logic signed [31:0]              o_s_xy,
    output logic signed [31:0]              o_s_yz,
    output logic signed [31:0]              o_s_xz,
    output logic                            o_bad_volume,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [abd_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import abd_pkg::*;

    localparam int F_SHIFT   = 24;
    localparam int OUT_SHIFT = 17;
    localparam logic [SQ_W-1:0] POS_MAX = 64'h7FFF_FFFF;
    localparam logic [SQ_W-1:0] NEG_MAX = 64'h8000_0000;

    typedef struct packed {
        logic  neg;
        t_side side;
    } t_fpay;

    localparam int FP_W = $bits(t_fpay);
    localparam int SD_W = $bits(t_side);

    logic w_en;

    // Register port.
    logic [31:0] r_mu;
    logic [31:0] r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu <= MU_RESET;
            r_n  <= N_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[ADDR_W-1])
                REG_MU: r_mu <= pwdata;
                REG_N:  r_n  <= pwdata;
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_N) ? r_n : r_mu;
    assign pready = 1'b1;

    // Stage A: trace and deviatoric numerators.
    logic signed [D_W-1:0]  w_xx, w_yy, w_zz, w_xy, w_yz, w_xz;
    logic signed [I1_W-1:0] w_a_i1;
    t_side                  w_a_side;
    logic                   r_a_vld;
    logic signed [I1_W-1:0] r_a_i1;
    t_side                  r_a_side;

    always_comb begin
        w_xx = D_W'(i_b_xx);
        w_yy = D_W'(i_b_yy);
        w_zz = D_W'(i_b_zz);
        w_xy = D_W'(i_b_xy);
        w_yz = D_W'(i_b_yz);
        w_xz = D_W'(i_b_xz);
        w_a_i1 = I1_W'(i_b_xx) + I1_W'(i_b_yy) + I1_W'(i_b_zz);
        w_a_side.bad  = i_volume_ratio[IN_W-1] || (i_volume_ratio == '0);
        w_a_side.j    = i_volume_ratio;
        w_a_side.d[0] = (w_xx <<< 1) - w_yy - w_zz;
        w_a_side.d[1] = (w_yy <<< 1) - w_xx - w_zz;
        w_a_side.d[2] = (w_zz <<< 1) - w_xx - w_yy;
        w_a_side.d[3] = w_xy + (w_xy <<< 1);
        w_a_side.d[4] = w_yz + (w_yz <<< 1);
        w_a_side.d[5] = w_xz + (w_xz <<< 1);
    end

    // Stage B: rounded numerator of I1/N.
    logic [I1_W-1:0]   w_b_ui;
    logic [I1_W-1:0]   w_b_mag;
    logic [NDEN_W-1:0] w_b_n;
    logic [FQ_W-1:0]   w_b_num;
    logic              r_b_vld;
    logic [FQ_W-1:0]   r_b_num;
    logic [NDEN_W-1:0] r_b_den;
    t_fpay             r_b_pay;

    assign w_b_ui  = r_a_i1;
    assign w_b_mag = r_a_i1[I1_W-1] ? (~w_b_ui + 1'b1) : w_b_ui;
    assign w_b_n   = (r_n == '0) ? NDEN_W'(1) : r_n;
    assign w_b_num = (FQ_W'(w_b_mag) << F_SHIFT) + FQ_W'(w_b_n >> 1);

    logic              w_fd_vld;
    logic [FQ_W-1:0]   w_fd_q;
    logic [FP_W-1:0]   w_fd_pay;
    t_fpay             w_fd_fp;

    abd_udiv #(
        .NUM_W(FQ_W),
        .DEN_W(NDEN_W),
        .PAY_W(FP_W)
    ) u_fdiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r_b_vld),
        .i_num  (r_b_num),
        .i_den  (r_b_den),
        .i_pay  (r_b_pay),
        .o_valid(w_fd_vld),
        .o_q    (w_fd_q),
        .o_pay  (w_fd_pay)
    );

    // Stage C: signed f.
    logic [F_W-1:0] w_c_fm;
    logic           r_c_vld;
    t_horn          r_c_pay;

    assign w_fd_fp = t_fpay'(w_fd_pay);
    assign w_c_fm  = {1'b0, w_fd_q};

    // Series by Horner's rule.
    logic signed [63:0] w_h_acc [5];
    t_horn              w_h_pay [5];
    logic               w_h_vld [5];

    assign w_h_acc[0] = signed'(SERIES[4]);
    assign w_h_pay[0] = r_c_pay;
    assign w_h_vld[0] = r_c_vld;

    for (genvar g = 0; g < 4; g++) begin : g_horner
        abd_horner #(
            .COEF(SERIES[3-g])
        ) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_h_vld[g]),
            .i_acc  (w_h_acc[g]),
            .i_pay  (w_h_pay[g]),
            .o_valid(w_h_vld[g+1]),
            .o_acc  (w_h_acc[g+1]),
            .o_pay  (w_h_pay[g+1])
        );
    end

    // W1 = mu * series.
    logic signed [63:0] w_w1;
    logic [SD_W-1:0]    w_w1_pay;
    logic               w_w1_vld;
    t_side              w_w1_side;

    abd_mul #(
        .AW   (33),
        .BW   (ACC_W),
        .SH   (16),
        .LIM  (SAT64),
        .PAY_W(SD_W)
    ) u_w1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(w_h_vld[4]),
        .i_a    (signed'({1'b0, r_mu})),
        .i_b    (w_h_acc[4]),
        .i_pay  (w_h_pay[4].side),
        .o_valid(w_w1_vld),
        .o_p    (w_w1),
        .o_pay  (w_w1_pay)
    );

    assign w_w1_side = t_side'(w_w1_pay);

    // t = W1 * d, one lane per component.
    logic signed [63:0] w_t [LANES];
    logic [IN_W:0]      w_t0_pay;
    logic               w_t_vld;

    abd_mul #(
        .AW   (ACC_W),
        .BW   (D_W),
        .SH   (32),
        .LIM  (T_LIMIT),
        .PAY_W(IN_W + 1)
    ) u_t0 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(w_w1_vld),
        .i_a    (w_w1),
        .i_b    (signed'(w_w1_side.d[0])),
        .i_pay  ({w_w1_side.bad, w_w1_side.j}),
        .o_valid(w_t_vld),
        .o_p    (w_t[0]),
        .o_pay  (w_t0_pay)
    );

    for (genvar g = 1; g < LANES; g++) begin : g_tmul
        abd_mul #(
            .AW   (ACC_W),
            .BW   (D_W),
            .SH   (32),
            .LIM  (T_LIMIT),
            .PAY_W(1)
        ) u_t (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_w1_vld),
            .i_a    (w_w1),
            .i_b    (signed'(w_w1_side.d[g])),
            .i_pay  (1'b0),
            .o_valid(),
            .o_p    (w_t[g]),
            .o_pay  ()
        );
    end

    // Stage D: rounded numerators of t*2^17/(3J).
    logic [DEN_W-1:0] w_d_den;
    logic [SQ_W-1:0]  w_d_mag [LANES];
    logic [SQ_W-1:0]  w_d_num [LANES];
    logic             r_d_vld;
    logic             r_d_bad;
    logic [DEN_W-1:0] r_d_den;
    logic [SQ_W-1:0]  r_d_num [LANES];
    logic             r_d_neg [LANES];

    assign w_d_den = DEN_W'(w_t0_pay[IN_W-1:0]) + (DEN_W'(w_t0_pay[IN_W-1:0]) << 1);

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_d_mag[k] = w_t[k][63] ? (~w_t[k] + 1'b1) : w_t[k];
            w_d_num[k] = (w_d_mag[k] << OUT_SHIFT) + SQ_W'(w_d_den >> 1);
        end
    end

    // Output dividers.
    logic [SQ_W-1:0] w_q [LANES];
    logic [1:0]      w_q0_pay;
    logic            w_qn_pay [LANES];
    logic            w_q_vld;

    abd_udiv #(
        .NUM_W(SQ_W),
        .DEN_W(DEN_W),
        .PAY_W(2)
    ) u_sdiv0 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r_d_vld),
        .i_num  (r_d_num[0]),
        .i_den  (r_d_den),
        .i_pay  ({r_d_bad, r_d_neg[0]}),
        .o_valid(w_q_vld),
        .o_q    (w_q[0]),
        .o_pay  (w_q0_pay)
    );

    assign w_qn_pay[0] = w_q0_pay[0];

    for (genvar g = 1; g < LANES; g++) begin : g_sdiv
        abd_udiv #(
            .NUM_W(SQ_W),
            .DEN_W(DEN_W),
            .PAY_W(1)
        ) u_sdiv (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(r_d_vld),
            .i_num  (r_d_num[g]),
            .i_den  (r_d_den),
            .i_pay  (r_d_neg[g]),
            .o_valid(),
            .o_q    (w_q[g]),
            .o_pay  (w_qn_pay[g])
        );
    end

    // Output saturation.
    logic [OUT_W-1:0] w_p_s [LANES];
    logic             w_p_bad;

    assign w_p_bad = w_q0_pay[1];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (w_p_bad) begin
                w_p_s[k] = '0;
            end else if (w_qn_pay[k]) begin
                w_p_s[k] = (w_q[k] > NEG_MAX) ? NEG_MAX[OUT_W-1:0]
                                              : (~w_q[k][OUT_W-1:0] + 1'b1);
            end else begin
                w_p_s[k] = (w_q[k] > POS_MAX) ? POS_MAX[OUT_W-1:0] : w_q[k][OUT_W-1:0];
            end
        end
    end

    // Pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= w_fd_vld;
            r_d_vld <= w_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_i1         <= w_a_i1;
            r_a_side       <= w_a_side;
            r_b_num        <= w_b_num;
            r_b_den        <= w_b_n;
            r_b_pay.neg    <= r_a_i1[I1_W-1];
            r_b_pay.side   <= r_a_side;
            r_c_pay.f      <= w_fd_fp.neg ? (~w_c_fm + 1'b1) : w_c_fm;
            r_c_pay.side   <= w_fd_fp.side;
            r_d_bad        <= w_t0_pay[IN_W];
            r_d_den        <= w_d_den;
            for (int k = 0; k < LANES; k++) begin
                r_d_num[k] <= w_d_num[k];
                r_d_neg[k] <= w_t[k][63];
            end
        end
    end

    // Output register and skid register.
    logic             r_out_vld;
    logic             r_out_bad;
    logic [OUT_W-1:0] r_out_s [LANES];
    logic             r_skid_vld;
    logic             r_skid_bad;
    logic [OUT_W-1:0] r_skid_s [LANES];
    logic             w_take;
    logic             w_free;

    assign w_en   = !r_skid_vld;
    assign w_take = r_out_vld && !i_stall;
    assign w_free = !r_out_vld || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_q_vld && !w_free) begin
            r_skid_vld <= 1'b1;
        end else if (w_q_vld) begin
            r_out_vld <= 1'b1;
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out_s   <= r_skid_s;
                r_out_bad <= r_skid_bad;
            end
        end else if (w_q_vld && !w_free) begin
            r_skid_s   <= w_p_s;
            r_skid_bad <= w_p_bad;
        end else if (w_q_vld) begin
            r_out_s   <= w_p_s;
            r_out_bad <= w_p_bad;
        end
    end

    assign o_stall      = r_skid_vld;
    assign o_valid      = r_out_vld;
    assign o_bad_volume = r_out_bad;
    assign o_s_xx       = signed'(r_out_s[0]);
    assign o_s_yy       = signed'(r_out_s[1]);
    assign o_s_zz       = signed'(r_out_s[2]);
    assign o_s_xy       = signed'(r_out_s[3]);
    assign o_s_yz       = signed'(r_out_s[4]);
    assign o_s_xz       = signed'(r_out_s[5]);
endmodule

`default_nettype wire

/* rtl/abd_checker.sv */
// Port-level checks of the deviatoric stress block, bound to its top level.
// Uses the assertion macros of arruda_boyce_deviatoric_stress_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "arruda_boyce_deviatoric_stress_defines.svh"

module abd_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_stall,
    input wire               o_valid,
    input wire               i_stall,
    input wire signed [31:0] o_s_xx,
    input wire signed [31:0] o_s_yy,
    input wire signed [31:0] o_s_zz,
    input wire signed [31:0] o_s_xy,
    input wire signed [31:0] o_s_yz,
    input wire signed [31:0] o_s_xz,
    input wire               o_bad_volume
);
    `ABD_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_s_xx) && $stable(o_s_xz) && $stable(o_bad_volume), "Stalled output beat changed.")
    `ABD_ASSERT(a_bad_zero, i_clk, i_rst_n, o_valid && o_bad_volume |-> o_s_xx == 0 && o_s_yy == 0 && o_s_zz == 0 && o_s_xy == 0 && o_s_yz == 0 && o_s_xz == 0, "Bad volume beat carries nonzero stress.")
    `ABD_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> $past(o_valid && i_stall), "Input stalled without a stalled output beat.")
    `ABD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && !o_stall, "Block not idle after reset.")
endmodule

bind arruda_boyce_deviatoric_stress abd_checker u_abd_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the Arruda-Boyce deviatoric stress pipeline.
// Needs abd_pkg and arruda_boyce_deviatoric_stress; it predicts each stress beat
// in fixed point, checks it on the output, and drives the APB port and both handshakes.
`timescale 1ns / 1ps

module testbench;
    import abd_pkg::*;

    typedef struct packed {
        logic [5:0][31:0] b;
        logic [31:0]      j;
    } point_t;

    typedef struct packed {
        logic [5:0][31:0] s;
        logic             bad;
    } stress_t;

    localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam bit [63:0] STRESS_T_LIM = 64'd3 << 45;
    localparam longint POLY [5] = '{
        64'sd2147483648, 64'sd858993459, 64'sd404954059, 64'sd186524294, 64'sd82711986
    };

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall, o_bad_volume;
    logic signed [31:0] i_b_xx, i_b_yy, i_b_zz, i_b_xy, i_b_yz, i_b_xz, i_volume_ratio;
    logic signed [31:0] o_s_xx, o_s_yy, o_s_zz, o_s_xy, o_s_yz, o_s_xz;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    logic [31:0] mu_cfg, links_cfg;
    stress_t pending_stress [$];
    int mismatches;
    bit sender_steady, stall_quiet, long_hold;

    arruda_boyce_deviatoric_stress dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic longint mul_round(longint a, longint b, int sh, bit [63:0] lim);
        bit neg;
        bit [63:0] ua, ub, q;
        bit [127:0] p;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        q = (p > {64'd0, lim}) ? lim : p[63:0];
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] stress_lane(longint w1, longint d, bit [63:0] den);
        longint t, v;
        bit [63:0] m, q;
        t = mul_round(w1, d, 32, STRESS_T_LIM);
        m = (t < 0) ? -t : t;
        q = ((m << 17) + den / 2) / den;
        if (t < 0) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            v = -longint'(q);
        end else begin
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            v = longint'(q);
        end
        return v[31:0];
    endfunction

    function automatic stress_t predict_stress(point_t p);
        stress_t r;
        longint b [6];
        longint jv, i1, f, acc, w1;
        bit [63:0] n, m, fm, den;
        r = '0;
        for (int k = 0; k < 6; k++) b[k] = $signed(p.b[5-k]);
        jv = $signed(p.j);
        if (jv <= 0) begin
            r.bad = 1'b1;
            return r;
        end
        i1 = b[0] + b[1] + b[2];
        n = (links_cfg != 0) ? {32'd0, links_cfg} : 64'd1;
        m = (i1 < 0) ? -i1 : i1;
        fm = ((m << 24) + n / 2) / n;
        f = (i1 < 0) ? -longint'(fm) : longint'(fm);
        acc = POLY[4];
        for (int k = 3; k >= 0; k--) begin
            acc = mul_round(acc, f, 32, MAX64);
            acc = (acc > MAX64 - POLY[k]) ? MAX64 : acc + POLY[k];
        end
        w1 = mul_round(longint'({32'd0, mu_cfg}), acc, 16, MAX64);
        den = 3 * jv;
        r.s[5] = stress_lane(w1, 2 * b[0] - b[1] - b[2], den);
        r.s[4] = stress_lane(w1, 2 * b[1] - b[0] - b[2], den);
        r.s[3] = stress_lane(w1, 2 * b[2] - b[0] - b[1], den);
        r.s[2] = stress_lane(w1, 3 * b[3], den);
        r.s[1] = stress_lane(w1, 3 * b[4], den);
        r.s[0] = stress_lane(w1, 3 * b[5], den);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] near(logic [31:0] centre, int spread);
        return centre + $urandom_range(0, 2 * spread) - spread;
    endfunction

    function automatic point_t random_point();
        point_t p;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            for (int k = 3; k < 6; k++) p.b[k] = near(32'h0100_0000, 1 << 22);
            for (int k = 0; k < 3; k++) p.b[k] = near(32'd0, 1 << 22);
            p.j = $urandom_range(1 << 22, 1 << 26);
        end else begin
            for (int k = 0; k < 6; k++) p.b[k] = $urandom;
            p.j = $urandom;
            if (r >= 90) p.j = $urandom_range(1, 255);
            if (r >= 96) p.j = -$urandom_range(0, 100);
        end
        return p;
    endfunction

    // Sends one beat and holds it until the pipeline takes it.
    task automatic send_point(point_t p);
        int gap;
        i_valid <= 1'b1;
        {i_b_xx, i_b_yy, i_b_zz, i_b_xy, i_b_yz, i_b_xz} <= p.b;
        i_volume_ratio <= p.j;
        do @(posedge i_clk); while (o_stall);
        pending_stress.push_back(predict_stress(p));
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_stress.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [31:0] value);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (index == REG_MU) mu_cfg = value;
        else links_cfg = value;
        @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) send_point(random_point());
    endtask

    task automatic test_directed();
        point_t p;
        p = '0; p.j = 32'h0100_0000; send_point(p);
        p = '1; p.b = {6{32'h7FFF_FFFF}}; p.j = 32'h7FFF_FFFF; send_point(p);
        p.b = {6{32'h8000_0000}}; send_point(p);
        p.j = 32'd1; send_point(p);
        p.b = {6{32'h7FFF_FFFF}}; send_point(p);
        p.j = 32'd0; send_point(p);
        p.j = 32'h8000_0000; send_point(p);
        p.j = 32'hFFFF_FFFF; send_point(p);
        p.b = {32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 96'd0};
        p.j = 32'h0100_0000; send_point(p);
        p.b = {32'h0200_0000, 32'h0080_0000, 32'h0080_0000, 32'h0040_0000,
               32'hFFC0_0000, 32'h0010_0000};
        send_point(p);
        p.j = 32'h0080_0000; send_point(p);
        p.b = {32'hFF00_0000, 32'hFF00_0000, 32'hFE00_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h0000_0001};
        send_point(p);
        p.b = {32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
               32'h3333_3333, 32'hCCCC_CCCC};
        p.j = 32'h7FFF_FFFF; send_point(p);
        for (int i = 0; i < 7; i++) send_point(random_point());
    endtask

    task automatic test_register_settings();
        logic [31:0] mus [5] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd50 << 16, 32'h0000_8000};
        logic [31:0] lks [5] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1 << 16, 32'd100 << 16};
        for (int s = 0; s < 5; s++) begin
            write_reg(REG_MU, mus[s]);
            write_reg(REG_N, lks[s]);
            send_random(90);
        end
        write_reg(REG_MU, $urandom);
        write_reg(REG_N, $urandom);
        send_random(90);
        write_reg(REG_MU, 32'd65536);
        write_reg(REG_N, 32'd524288);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        sender_steady = 1;
        long_hold = 1;
        send_random(300);
        sender_steady = 0;
    endtask

    task automatic test_sender_pause();
        send_random(40);
        wait_drained();
        send_random(40);
    endtask

    task automatic test_random_stream();
        for (int seg = 0; seg < 10; seg++) begin
            sender_steady = (seg % 3 == 1);
            stall_quiet = (seg % 4 == 2);
            send_random(31);
        end
        sender_steady = 0;
        stall_quiet = 0;
    endtask

    initial begin : stall_gen
        int n;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                long_hold = 0;
            end else if (stall_quiet || $urandom_range(0, 3) != 0) begin
                i_stall <= 1'b0;
            end else begin
                n = pick_gap();
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        stress_t want;
        stress_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.s = {o_s_xx, o_s_yy, o_s_zz, o_s_xy, o_s_yz, o_s_xz};
            got.bad = o_bad_volume;
            if (pending_stress.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat s=%h bad=%b", $time, got.s, got.bad);
            end else begin
                want = pending_stress.pop_front();
                for (int k = 5; k >= 0; k--) begin
                    if (got.s[k] !== want.s[k]) begin
                        mismatches++;
                        $display("%0t: stress lane %0d expected %h actual %h",
                                 $time, 5 - k, want.s[k], got.s[k]);
                    end
                end
                if (got.bad !== want.bad) begin
                    mismatches++;
                    $display("%0t: bad_volume expected %b actual %b",
                             $time, want.bad, got.bad);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        {i_b_xx, i_b_yy, i_b_zz, i_b_xy, i_b_yz, i_b_xz, i_volume_ratio} = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        mu_cfg = MU_RESET;
        links_cfg = N_RESET;
        mismatches = 0;
        sender_steady = 0;
        stall_quiet = 0;
        long_hold = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_settings();
        test_output_backpressure();
        test_sender_pause();
        test_random_stream();
        wait_drained();
        repeat (160) @(posedge i_clk);
        if (mismatches == 0 && pending_stress.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/abd_pkg.sv
rtl/abd_udiv.sv
rtl/abd_mul.sv
rtl/abd_horner.sv
rtl/arruda_boyce_deviatoric_stress.sv
rtl/abd_checker.sv
tb/testbench.sv
